>>> hw/rtl/rps_pkg.sv
package rps_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int unsigned HIST_DEPTH        = 10;
  localparam int unsigned WIN_W             = HIST_DEPTH + 1;
  localparam int unsigned SQL_COUNT         = 8;
  localparam int unsigned XSS_COUNT         = 5;
  localparam int unsigned CFG_IDX_W         = 2;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_BODY  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    DENY_NONE      = 3'd0,
    DENY_INVALID   = 3'd1,
    DENY_RATE      = 3'd2,
    DENY_SQL       = 3'd3,
    DENY_XSS       = 3'd4,
    DENY_TOO_LARGE = 3'd5
  } deny_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_EN    = 2'd0,
    CFG_RATE_COUNT = 2'd1,
    CFG_XSS_EN     = 2'd2,
    CFG_MAX_BODY   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] decl_len;
    logic        fields_present;
  } in_item_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] deny_reason;
  } out_item_t;

  typedef struct packed {
    logic        rate_en;
    logic [31:0] rate_count;
    logic        xss_en;
    logic [31:0] max_body;
  } cfg_t;

  typedef struct packed {
    logic sql_seen;
    logic xss_seen;
  } scan_flags_t;

  // Patterns are right-justified: the last character sits in the low byte,
  // unused high bytes are zero and act as don't-care.
  typedef logic [WIN_W*8-1:0] pat_t;
  typedef logic [WIN_W-1:0][7:0] win_t;

  localparam pat_t SQL_PAT [SQL_COUNT] = '{
    "SELECT", "INSERT", "UPDATE", "DELETE", "DROP", "UNION", "OR 1=1", "--"
  };

  localparam pat_t XSS_PAT [XSS_COUNT] = '{
    "<SCRIPT", "JAVASCRIPT:", "ONERROR=", "ONLOAD=", "EVAL("
  };

  function automatic logic pat_hit(win_t win, pat_t pat);
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < WIN_W; k++) begin
      if (pat[8*k +: 8] != 8'h00 && win[k] != pat[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/rps_scan.sv
module rps_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,
  input  rps_pkg::in_item_t    item,
  output rps_pkg::scan_flags_t flags
);
  import rps_pkg::*;

  logic [HIST_DEPTH-1:0][7:0] hist_r, hist_nxt;
  logic [1:0]                 part_r, part_nxt;
  logic                       ended_r, ended_nxt;
  logic                       sql_r, sql_nxt;
  logic                       xss_r, xss_nxt;

  logic [HIST_DEPTH-1:0][7:0] hist_eff;
  logic                       part_change;
  logic                       ended_eff;
  logic [7:0]                 ub;
  win_t                       win;
  logic                       sql_hit, xss_hit;

  always_comb begin
    part_change = (item.kind != part_r);
    ended_eff   = part_change ? 1'b0 : ended_r;
    hist_eff    = part_change ? '0 : hist_r;
    ub          = to_upper(item.data_byte);
    win         = {hist_eff, ub};
  end

  always_comb begin
    sql_hit = 1'b0;
    for (int i = 0; i < SQL_COUNT; i++) begin
      if (pat_hit(win, SQL_PAT[i])) sql_hit = 1'b1;
    end
    xss_hit = 1'b0;
    for (int i = 0; i < XSS_COUNT; i++) begin
      if (pat_hit(win, XSS_PAT[i])) xss_hit = 1'b1;
    end
  end

  always_comb begin
    hist_nxt  = hist_r;
    part_nxt  = part_r;
    ended_nxt = ended_r;
    sql_nxt   = sql_r;
    xss_nxt   = xss_r;
    if (proc) begin
      case (item.kind)
        KIND_START: begin
          hist_nxt  = '0;
          part_nxt  = KIND_START;
          ended_nxt = 1'b0;
          sql_nxt   = 1'b0;
          xss_nxt   = 1'b0;
        end
        KIND_QUERY, KIND_BODY: begin
          part_nxt  = item.kind;
          hist_nxt  = hist_eff;
          ended_nxt = ended_eff;
          if (!ended_eff) begin
            if (item.data_byte == 8'h00) begin
              ended_nxt = 1'b1;
            end else begin
              hist_nxt = {hist_eff[HIST_DEPTH-2:0], ub};
              sql_nxt  = sql_r | sql_hit;
              xss_nxt  = xss_r | xss_hit;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      part_r  <= KIND_START;
      ended_r <= 1'b0;
      sql_r   <= 1'b0;
      xss_r   <= 1'b0;
    end else begin
      hist_r  <= hist_nxt;
      part_r  <= part_nxt;
      ended_r <= ended_nxt;
      sql_r   <= sql_nxt;
      xss_r   <= xss_nxt;
    end
  end

  assign flags.sql_seen = sql_r;
  assign flags.xss_seen = xss_r;

endmodule

>>> hw/rtl/rps_verdict.sv
module rps_verdict #(
  parameter int unsigned COUNTER_WIDTH = rps_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc,
  input  rps_pkg::in_item_t    item,
  input  rps_pkg::cfg_t        cfg,
  input  rps_pkg::scan_flags_t flags,
  output rps_pkg::out_item_t   verdict
);
  import rps_pkg::*;

  localparam int unsigned CMP_W = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;

  logic [COUNTER_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [2:0]               early_r, early_nxt;
  logic                     big_r, big_nxt;
  logic [CMP_W-1:0]         cnt_ext, lim_ext;
  logic [2:0]               reason;

  always_comb begin
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    cnt_ext = CMP_W'(cnt_inc);
    lim_ext = CMP_W'(cfg.rate_count);
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    early_nxt = early_r;
    big_nxt   = big_r;
    if (proc && item.kind == KIND_START) begin
      big_nxt   = (item.decl_len > cfg.max_body);
      early_nxt = DENY_NONE;
      if (!item.fields_present) begin
        early_nxt = DENY_INVALID;
      end else if (cfg.rate_en) begin
        cnt_nxt = cnt_inc;
        if (cnt_ext > lim_ext) early_nxt = DENY_RATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      early_r <= DENY_NONE;
      big_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      early_r <= early_nxt;
      big_r   <= big_nxt;
    end
  end

  // priority: early (invalid/rate), sql, xss, too large
  always_comb begin
    if (early_r != DENY_NONE)              reason = early_r;
    else if (flags.sql_seen)               reason = DENY_SQL;
    else if (cfg.xss_en && flags.xss_seen) reason = DENY_XSS;
    else if (big_r)                        reason = DENY_TOO_LARGE;
    else                                   reason = DENY_NONE;
    verdict.deny_reason = reason;
    verdict.allowed     = (reason == DENY_NONE);
  end

endmodule

>>> hw/rtl/request_pattern_screen.sv
// Path: an end beat passes the input register, then the result register, before its verdict shows on out_valid.
// Throughput: one beat per cycle unless a held verdict stalls; the input register, one pass of pattern
// compare against the ten-byte history, and the result register set the pace.
// Only a held verdict (out_stall) stalls an end beat in the input register, and every beat behind it.
// Reset: synchronous on rst_n low; history, flags, counter and config clear to zero.
module request_pattern_screen #(
  parameter int unsigned COUNTER_WIDTH = rps_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rps_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rps_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [rps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import rps_pkg::*;

  logic        in_v_r;
  in_item_t    in_item_r;
  logic        out_v_r;
  out_item_t   out_item_r;
  cfg_t        cfg_r;
  logic        adv, proc, take_in;
  scan_flags_t flags;
  out_item_t   verdict;

  // only an end beat needs the result register
  assign adv      = (in_item_r.kind != KIND_END) || !out_v_r || !out_stall;
  assign proc     = in_v_r && adv;
  assign in_stall = in_v_r && !adv;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (take_in) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && in_item_r.kind == KIND_END) begin
      out_v_r <= 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_item_r.kind == KIND_END) begin
      out_item_r <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE_EN:    cfg_r.rate_en    <= cfg_wdata[0];
        CFG_RATE_COUNT: cfg_r.rate_count <= cfg_wdata;
        CFG_XSS_EN:     cfg_r.xss_en     <= cfg_wdata[0];
        CFG_MAX_BODY:   cfg_r.max_body   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rps_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .item  (in_item_r),
    .flags (flags)
  );

  rps_verdict #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_verdict (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (proc),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .flags   (flags),
    .verdict (verdict)
  );

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

>>> hw/rtl/rps_checker.sv
module rps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rps_pkg::out_item_t out_item
);
  import rps_pkg::*;

  // a held verdict beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("verdict beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict beat right after reset");

  // input backpressure only comes from a blocked verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_allow_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.allowed == (out_item.deny_reason == DENY_NONE)))
    else $error("allowed flag disagrees with deny reason");

endmodule

bind request_pattern_screen rps_checker u_rps_checker (.*);

>>> sim/testbench.sv
module testbench;
  import rps_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;

  class verdict_ledger;
    bit                         rate_on;
    bit [31:0]                  rate_cap;
    bit                         xss_on;
    bit [31:0]                  body_limit;

    bit [7:0]                   trail [HIST_DEPTH];
    int unsigned                trail_fill;
    kind_t                      part;
    bit                         part_done;
    bit                         sql_hit;
    bit                         xss_hit;
    deny_t                      held_reason;
    bit                         oversize;
    bit [COUNTER_WIDTH_DEF-1:0] req_count;

    out_item_t                  due_verdicts [$];
    int unsigned                errors;
    string                      sql_words [SQL_COUNT];
    string                      xss_words [XSS_COUNT];

    function new();
      part = KIND_START;
      held_reason = DENY_NONE;
      sql_words = '{"SELECT", "INSERT", "UPDATE", "DELETE", "DROP", "UNION", "OR 1=1", "--"};
      xss_words = '{"<SCRIPT", "JAVASCRIPT:", "ONERROR=", "ONLOAD=", "EVAL("};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_RATE_EN:    rate_on = v[0];
        CFG_RATE_COUNT: rate_cap = v;
        CFG_XSS_EN:     xss_on = v[0];
        CFG_MAX_BODY:   body_limit = v;
        default: ;
      endcase
    endfunction

    function void forget_trail();
      foreach (trail[i]) trail[i] = 8'h00;
      trail_fill = 0;
    endfunction

    // word ends on byte c, with trail[0] the byte just before c
    function bit ends_on(string w, bit [7:0] c);
      int n;
      n = w.len();
      if (n == 0 || n > trail_fill + 1) return 1'b0;
      if (w[n-1] != c) return 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        if (i >= HIST_DEPTH || w[n-2-i] != trail[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void scan_byte(kind_t k, bit [7:0] b);
      if (k != part) begin
        part = k;
        part_done = 1'b0;
        forget_trail();
      end
      if (part_done) return;
      if (b == 8'h00) begin
        part_done = 1'b1;
        return;
      end
      if (b >= 8'h61 && b <= 8'h7A) b = b - 8'd32;
      foreach (sql_words[i]) if (ends_on(sql_words[i], b)) sql_hit = 1'b1;
      foreach (xss_words[i]) if (ends_on(xss_words[i], b)) xss_hit = 1'b1;
      for (int i = HIST_DEPTH - 1; i > 0; i--) trail[i] = trail[i-1];
      trail[0] = b;
      if (trail_fill < HIST_DEPTH) trail_fill++;
    endfunction

    function void note_beat(in_item_t it);
      deny_t     reason;
      out_item_t v;
      case (kind_t'(it.kind))
        KIND_START: begin
          forget_trail();
          part = KIND_START;
          part_done = 1'b0;
          sql_hit = 1'b0;
          xss_hit = 1'b0;
          held_reason = DENY_NONE;
          oversize = it.decl_len > body_limit;
          if (!it.fields_present) begin
            held_reason = DENY_INVALID;
          end else if (rate_on) begin
            if (req_count != '1) req_count++;
            if (req_count > rate_cap) held_reason = DENY_RATE;
          end
        end
        KIND_QUERY, KIND_BODY: scan_byte(kind_t'(it.kind), it.data_byte);
        default: begin
          if (held_reason != DENY_NONE) reason = held_reason;
          else if (sql_hit) reason = DENY_SQL;
          else if (xss_on && xss_hit) reason = DENY_XSS;
          else if (oversize) reason = DENY_TOO_LARGE;
          else reason = DENY_NONE;
          v.allowed = (reason == DENY_NONE);
          v.deny_reason = reason;
          due_verdicts.push_back(v);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_verdict(out_item_t got);
      out_item_t want;
      if (due_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict allowed=%0b reason=%0d with none outstanding",
                                  got.allowed, got.deny_reason));
        return;
      end
      want = due_verdicts.pop_front();
      if (got.allowed !== want.allowed) begin
        report_mismatch($sformatf("allowed %0b, expected %0b", got.allowed, want.allowed));
      end
      if (got.deny_reason !== want.deny_reason) begin
        report_mismatch($sformatf("deny_reason %0d, expected %0d",
                                  got.deny_reason, want.deny_reason));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  verdict_ledger ledger;
  bit            in_gaps;
  bit            quiet;
  int unsigned   beats_sent;
  int unsigned   stuck;

  request_pattern_screen dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_beat(in_item);
      if (out_valid && !out_stall) ledger.check_verdict(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck <= 0;
      end else if (stuck == STUCK_LIMIT) begin
        $display("request_pattern_screen regression: fail");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  // receiver back-pressure in bursts, none once the run goes quiet
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic send_beat(kind_t k, logic [7:0] b, logic [31:0] len, logic present);
    in_item_t it;
    it.kind = k;
    it.data_byte = b;
    it.decl_len = len;
    it.fields_present = present;
    if (in_gaps && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_char(kind_t k, logic [7:0] b);
    send_beat(k, b, $urandom, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] vary_case(logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A && $urandom_range(0, 1)) return b + 8'd32;
    return b;
  endfunction

  task automatic send_text(kind_t k, string s, bit mix);
    for (int i = 0; i < s.len(); i++) send_char(k, mix ? vary_case(s[i]) : s[i]);
  endtask

  task automatic send_field(kind_t k);
    int    flavor;
    int    pick;
    string w;
    flavor = $urandom_range(0, 2);  // 0 plain text, 1 script words only, 2 any word
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 1)) w = ledger.sql_words[$urandom_range(0, SQL_COUNT - 1)];
      else w = ledger.xss_words[$urandom_range(0, XSS_COUNT - 1)];
      if (pick == 0) begin
        send_char(k, 8'h00);
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 3)) send_char(k, 8'($urandom_range(0, 255)));
      end else if (pick <= 4 && flavor == 1) begin
        send_text(k, ledger.xss_words[$urandom_range(0, XSS_COUNT - 1)], 1'b1);
      end else if (pick <= 4 && flavor == 2) begin
        send_text(k, w, 1'b1);
      end else if (pick == 5) begin
        // one character short of a word
        send_text(k, w.substr(0, w.len() - 2), 1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 2) != 0) begin
            send_char(k, vary_case(8'h41 + 8'($urandom_range(0, 25))));
          end else begin
            send_char(k, 8'($urandom_range(32, 126)));
          end
        end
      end
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    int          shape;
    logic [31:0] len;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      in_gaps = $urandom_range(0, 2) != 0;
      shape = $urandom_range(0, 11);
      if (shape == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom,
                    1'($urandom_range(0, 1)));
        end
      end else begin
        case ($urandom_range(0, 6))
          0: len = '0;
          1: len = '1;
          2: len = ledger.body_limit;
          3: len = ledger.body_limit + 32'd1;
          4: len = ledger.body_limit - 32'd1;
          5: len = $urandom;
          default: len = $urandom_range(0, 300);
        endcase
        send_beat(KIND_START, 8'($urandom_range(0, 255)), len, $urandom_range(0, 11) != 0);
        if ($urandom_range(0, 3) != 0) send_field(KIND_QUERY);
        if ($urandom_range(0, 1)) send_field(KIND_BODY);
        if ($urandom_range(0, 4) == 0) send_field(KIND_QUERY);
        // shape 1 skips this end; an open request is dropped by the next start
        if (shape != 1) begin
          send_beat(KIND_END, 8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) == 0) begin
          send_beat(KIND_END, 8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.due_verdicts.size() != 0) @(posedge clk);
    // start and byte beats owe no verdict but may still be in the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    ledger.set_reg(idx, v);
  endtask

  task automatic load_settings(logic rate_on, logic [31:0] rate_cap, logic xss_on,
                               logic [31:0] body_cap);
    cfg_we <= 1'b1;
    put_reg(CFG_RATE_EN, {31'd0, rate_on});
    put_reg(CFG_RATE_COUNT, rate_cap);
    put_reg(CFG_XSS_EN, {31'd0, xss_on});
    put_reg(CFG_MAX_BODY, body_cap);
    cfg_we <= 1'b0;
  endtask

  initial begin
    ledger = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // stray end and byte before any request act on reset state
    send_beat(KIND_END, 8'hFF, '1, 1'b0);
    send_char(KIND_QUERY, "x");
    // word split across query and body must not match
    send_beat(KIND_START, 8'h00, '0, 1'b1);
    send_text(KIND_QUERY, "sel", 1'b0);
    send_text(KIND_BODY, "ect", 1'b0);
    send_beat(KIND_END, 8'h00, '0, 1'b1);
    // zero closes the field, the second dash is dropped; oversize body
    send_beat(KIND_START, 8'hFF, '1, 1'b1);
    send_char(KIND_QUERY, "-");
    send_char(KIND_QUERY, 8'h00);
    send_char(KIND_QUERY, "-");
    send_beat(KIND_END, 8'h0F, 32'h5555_5555, 1'b0);
    send_beat(KIND_END, 8'hF0, 32'hAAAA_AAAA, 1'b1);
    // missing fields outrank sql
    send_beat(KIND_START, 8'h5A, '0, 1'b0);
    send_text(KIND_QUERY, "--", 1'b0);
    send_beat(KIND_END, 8'h00, '0, 1'b0);
    send_beat(KIND_START, 8'hA5, '0, 1'b1);
    send_text(KIND_BODY, "dRoP", 1'b0);
    send_beat(KIND_END, 8'h00, '0, 1'b1);
    run_random(100);

    settle();
    load_settings(1'b1, '0, 1'b1, '1);
    run_random(70);

    settle();
    load_settings(1'b1, ledger.req_count + $urandom_range(3, 15), 1'b1, $urandom_range(20, 200));
    run_random(200);

    settle();
    load_settings(1'b0, '1, 1'b1, '0);
    run_random(180);

    settle();
    load_settings(1'b1, '1, 1'b0, $urandom);
    run_random(160);

    quiet = 1'b1;
    settle();
    load_settings(1'b0, $urandom, 1'b1, '1);
    run_random(140);

    settle();
    if (ledger.errors == 0 && ledger.due_verdicts.size() == 0) begin
      $display("request_pattern_screen regression: pass");
    end else begin
      $display("request_pattern_screen regression: fail");
    end
    $finish;
  end
endmodule
